### rtl/segregated_pool_allocator_assert.svh
// assertion macros shared by the allocator modules
`ifndef SEGREGATED_POOL_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_POOL_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");
// next-cycle implication
`define SPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");
`else
`define SPA_ASSERT_IMPL(lbl, ante, cons)
`define SPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/spa_pkg.sv
// shared types, constants and class function of the pool allocator
package spa_pkg;

	localparam int POOL_CHUNKS     = 64;
	localparam int CHUNK_W         = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
	localparam int CU_W            = $clog2(POOL_CHUNKS + 1);
	localparam int SLOT_OFF_W      = 7;
	localparam int SLOT_W          = CHUNK_W + SLOT_OFF_W;
	localparam int NUM_SLOTS       = POOL_CHUNKS << SLOT_OFF_W;
	localparam int NUM_CLASSES     = 8;
	localparam int CLS_W           = 3;
	localparam int ADDR_W          = 18;
	localparam int SIZE_W          = 16;
	localparam int SLOT_SHIFT      = 5;
	localparam int HDR_BYTES       = 8;
	localparam int MAX_SMALL       = 4088;
	localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(NUM_CLASSES - 1);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_ZERO      = 2'd1;
	localparam logic [1:0] STAT_TOO_BIG   = 2'd2;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic              has_next;
		logic [SLOT_W-1:0] next;
	} hdr_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic carve_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_carve;
		logic carve_last;
		logic out_free;
	} dp_stat_t;

	// smallest class whose block holds need bytes, clamped to the largest
	function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W:0] need);
		logic [CLS_W-1:0] c;
		c = LAST_CLASS;
		for (int k = NUM_CLASSES - 2; k >= 0; k--) begin
			if (need <= (SIZE_W + 1)'(32'd1 << (k + SLOT_SHIFT)))
				c = CLS_W'(k);
		end
		return c;
	endfunction

endpackage

### rtl/spa_ram.sv
// generic single-write, single-read ram with registered read data
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/spa_datapath.sv
// allocator datapath: list heads, chunk count, header memory, carve counter, result register
`include "segregated_pool_allocator_assert.svh"
module spa_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spa_pkg::ctl_cmd_t            cmd,
	output spa_pkg::dp_stat_t            st,
	input  logic                         kind,
	input  logic [spa_pkg::SIZE_W-1:0]   req_size,
	input  logic [spa_pkg::ADDR_W-1:0]   block_addr,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [spa_pkg::ADDR_W-1:0]   result_addr,
	output logic [1:0]                   status
);

	logic [spa_pkg::NUM_CLASSES-1:0] head_valid_q;
	logic [spa_pkg::SLOT_W-1:0]      head_slot_q [spa_pkg::NUM_CLASSES];
	logic [spa_pkg::CU_W-1:0]        chunks_used_q;
	logic                            out_valid_q;
	logic [spa_pkg::ADDR_W-1:0]      result_addr_q;
	logic [1:0]                      status_q;

	logic                            kind_q;
	logic                            zero_q;
	logic                            big_q;
	logic [spa_pkg::CLS_W-1:0]       cls_q;
	logic                            free_ok_q;
	logic [spa_pkg::SLOT_W-1:0]      free_slot_q;
	logic [spa_pkg::SLOT_OFF_W-1:0]  carve_off_q;

	logic [spa_pkg::CLS_W-1:0]       in_cls;
	logic                            in_free_ok;
	logic [spa_pkg::SLOT_W-1:0]      rd_addr;
	logic [$bits(spa_pkg::hdr_t)-1:0] ram_rdata;
	spa_pkg::hdr_t                   rd_hdr;
	spa_pkg::hdr_t                   wr_hdr;
	logic                            wr_en;
	logic [spa_pkg::SLOT_W-1:0]      wr_addr;

	logic                            exhausted;
	logic                            alloc_ok;
	logic                            pop;
	logic                            carve;
	logic [spa_pkg::CLS_W-1:0]       fr_cls;
	logic [spa_pkg::CHUNK_W-1:0]     chunk_idx;
	logic [spa_pkg::SLOT_OFF_W:0]    step;
	logic [spa_pkg::SLOT_OFF_W:0]    carve_nxt;
	logic [spa_pkg::SLOT_W-1:0]      carve_addr;
	logic [spa_pkg::SLOT_W-1:0]      base_slot;
	logic [spa_pkg::ADDR_W-1:0]      commit_addr;
	logic [1:0]                      commit_status;

	// decode at accept
	assign in_cls = spa_pkg::size_class({1'b0, req_size}
		+ (spa_pkg::SIZE_W + 1)'(spa_pkg::HDR_BYTES));
	// a freeable block pointer has low bits equal to the header size and points into a carved chunk
	assign in_free_ok = (block_addr[spa_pkg::SLOT_SHIFT-1:0]
		== spa_pkg::SLOT_SHIFT'(spa_pkg::HDR_BYTES))
		&& (32'(block_addr[spa_pkg::ADDR_W-1:spa_pkg::SLOT_SHIFT])
		< (32'(chunks_used_q) << spa_pkg::SLOT_OFF_W));
	assign rd_addr = (kind == spa_pkg::KIND_FREE)
		? spa_pkg::SLOT_W'(block_addr[spa_pkg::ADDR_W-1:spa_pkg::SLOT_SHIFT])
		: head_slot_q[in_cls];

	assign rd_hdr    = spa_pkg::hdr_t'(ram_rdata);
	assign exhausted = chunks_used_q >= spa_pkg::CU_W'(spa_pkg::POOL_CHUNKS);
	assign alloc_ok  = (kind_q == spa_pkg::KIND_ALLOC) && !zero_q && !big_q;
	assign pop       = alloc_ok && head_valid_q[cls_q];
	assign carve     = alloc_ok && !head_valid_q[cls_q] && !exhausted;
	assign fr_cls    = rd_hdr.cls;

	// carving walks the chunk one block at a time
	assign chunk_idx  = chunks_used_q[spa_pkg::CHUNK_W-1:0];
	assign step       = (spa_pkg::SLOT_OFF_W + 1)'(1) << cls_q;
	assign carve_nxt  = {1'b0, carve_off_q} + step;
	assign carve_addr = {chunk_idx, carve_off_q};
	assign base_slot  = {chunk_idx, {spa_pkg::SLOT_OFF_W{1'b0}}};

	always_comb begin
		wr_en  = 1'b0;
		wr_addr = carve_addr;
		wr_hdr.cls      = cls_q;
		wr_hdr.has_next = !carve_nxt[spa_pkg::SLOT_OFF_W];
		wr_hdr.next     = carve_nxt[spa_pkg::SLOT_OFF_W] ? '0
			: {chunk_idx, carve_nxt[spa_pkg::SLOT_OFF_W-1:0]};
		if (cmd.carve_step) begin
			wr_en = 1'b1;
		end else if (cmd.commit && kind_q == spa_pkg::KIND_FREE && free_ok_q) begin
			wr_en           = 1'b1;
			wr_addr         = free_slot_q;
			wr_hdr.cls      = fr_cls;
			wr_hdr.has_next = head_valid_q[fr_cls];
			wr_hdr.next     = head_slot_q[fr_cls];
		end
	end

	always_comb begin
		commit_addr   = '0;
		commit_status = spa_pkg::STAT_OK;
		if (kind_q == spa_pkg::KIND_ALLOC) begin
			if (zero_q)
				commit_status = spa_pkg::STAT_ZERO;
			else if (big_q)
				commit_status = spa_pkg::STAT_TOO_BIG;
			else if (pop)
				commit_addr = spa_pkg::ADDR_W'({head_slot_q[cls_q], {spa_pkg::SLOT_SHIFT{1'b0}}})
					+ spa_pkg::ADDR_W'(spa_pkg::HDR_BYTES);
			else if (carve)
				commit_addr = spa_pkg::ADDR_W'({base_slot, {spa_pkg::SLOT_SHIFT{1'b0}}})
					+ spa_pkg::ADDR_W'(spa_pkg::HDR_BYTES);
			else
				commit_status = spa_pkg::STAT_EXHAUSTED;
		end
	end

	spa_ram #(
		.WIDTH($bits(spa_pkg::hdr_t)),
		.DEPTH(spa_pkg::NUM_SLOTS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_hdr),
		.re   (cmd.accept),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q  <= '0;
			chunks_used_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (kind_q == spa_pkg::KIND_FREE) begin
					if (free_ok_q)
						head_valid_q[fr_cls] <= 1'b1;
				end else if (pop) begin
					head_valid_q[cls_q] <= rd_hdr.has_next;
				end else if (carve) begin
					head_valid_q[cls_q] <= (cls_q != spa_pkg::LAST_CLASS);
					chunks_used_q       <= chunks_used_q + spa_pkg::CU_W'(1);
				end
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q      <= kind;
			zero_q      <= (req_size == '0);
			big_q       <= (req_size > spa_pkg::SIZE_W'(spa_pkg::MAX_SMALL));
			cls_q       <= in_cls;
			free_ok_q   <= in_free_ok;
			free_slot_q <= spa_pkg::SLOT_W'(block_addr[spa_pkg::ADDR_W-1:spa_pkg::SLOT_SHIFT]);
			carve_off_q <= '0;
		end else if (cmd.carve_step) begin
			carve_off_q <= carve_nxt[spa_pkg::SLOT_OFF_W-1:0];
		end
		if (cmd.commit) begin
			result_addr_q <= commit_addr;
			status_q      <= commit_status;
			if (kind_q == spa_pkg::KIND_FREE) begin
				if (free_ok_q)
					head_slot_q[fr_cls] <= free_slot_q;
			end else if (pop) begin
				head_slot_q[cls_q] <= rd_hdr.next;
			end else if (carve) begin
				head_slot_q[cls_q] <= {chunk_idx, step[spa_pkg::SLOT_OFF_W-1:0]};
			end
		end
	end

	assign st.need_carve = carve;
	assign st.carve_last = carve_nxt[spa_pkg::SLOT_OFF_W];
	assign st.out_free   = !out_valid_q || !rsp_stall;

	assign rsp_valid   = out_valid_q;
	assign result_addr = result_addr_q;
	assign status      = status_q;

	`SPA_ASSERT_IMPL(a_commit_room, cmd.commit, !out_valid_q || !rsp_stall)
	`SPA_ASSERT_IMPL(a_chunks_bound, 1'b1, chunks_used_q <= spa_pkg::CU_W'(spa_pkg::POOL_CHUNKS))
	`SPA_ASSERT_NEXT(a_carve_bump, cmd.commit && carve, chunks_used_q == $past(chunks_used_q) + spa_pkg::CU_W'(1))

endmodule

### rtl/spa_ctrl.sv
// allocator controller: accept, header lookup, chunk carving, result commit
`include "segregated_pool_allocator_assert.svh"
module spa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spa_pkg::dp_stat_t st,
	output spa_pkg::ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_CARVE = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (st.need_carve) begin
					state_d = ST_CARVE;
				end else if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_CARVE: begin
				cmd.carve_step = 1'b1;
				if (st.carve_last)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign req_stall = (state_q != ST_IDLE);

	`SPA_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_q == ST_EXEC)
	`SPA_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0({cmd.accept, cmd.commit, cmd.carve_step}))

endmodule

### rtl/segregated_pool_allocator.sv
// segregated power-of-two pool allocator, result registered after the commit cycle
// a pop, free or failed request takes one header memory read then a commit; no new request is taken before the commit
// an allocate from an empty class list carves a fresh chunk into 128 >> class blocks, one header write
// a cycle through the single write port of the header memory
// async reset clears all class lists, the chunk count and the handshake state; header memory is not cleared
module segregated_pool_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       kind,
	input  logic [spa_pkg::SIZE_W-1:0] req_size,
	input  logic [spa_pkg::ADDR_W-1:0] block_addr,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [spa_pkg::ADDR_W-1:0] result_addr,
	output logic [1:0]                 status
);

	spa_pkg::ctl_cmd_t cmd;
	spa_pkg::dp_stat_t st;

	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.st       (st),
		.cmd      (cmd)
	);

	spa_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.kind       (kind),
		.req_size   (req_size),
		.block_addr (block_addr),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.result_addr(result_addr),
		.status     (status)
	);

endmodule

### sim/tb_top.sv
// testbench for the segregated pool allocator: directed table, then random traffic checked by a predictor
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_PERIOD      = 10;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int SETTLE_CYCLES   = 300;
	localparam int HOLD_CYCLES     = 400;
	localparam int SLOTS_PER_CHUNK = 1 << spa_pkg::SLOT_OFF_W;
	localparam int DIRECTED_ROWS   = 24;

	typedef enum {MIX_GENERAL, MIX_FILL} mix_t;

	typedef struct {
		logic [spa_pkg::ADDR_W-1:0] addr;
		logic [1:0]                 status;
	} grant_t;

	typedef struct {
		logic                       op;
		logic [spa_pkg::SIZE_W-1:0] size;
		logic [spa_pkg::ADDR_W-1:0] ptr;
		bit                         known;
		logic [spa_pkg::ADDR_W-1:0] want_addr;
		logic [1:0]                 want_status;
	} vector_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	logic                       kind = spa_pkg::KIND_ALLOC;
	logic [spa_pkg::SIZE_W-1:0] req_size = '0;
	logic [spa_pkg::ADDR_W-1:0] block_addr = '0;
	logic                       rsp_valid;
	logic                       rsp_stall = 1'b0;
	logic [spa_pkg::ADDR_W-1:0] result_addr;
	logic [1:0]                 status;

	// predictor state
	bit                         head_valid [spa_pkg::NUM_CLASSES];
	logic [spa_pkg::SLOT_W-1:0] head_slot [spa_pkg::NUM_CLASSES] = '{default: '0};
	int unsigned                carved;
	spa_pkg::hdr_t              slot_hdr [spa_pkg::NUM_SLOTS];

	grant_t                     pending_grants [$];
	logic [spa_pkg::ADDR_W-1:0] live_ptrs [$];
	vector_t                    dir_rows [DIRECTED_ROWS];
	int                         err_count = 0;
	int                         cycle_count = 0;
	int                         send_idle_pct = 0;
	int                         stall_pct = 0;
	bit                         exhausted_seen = 1'b0;
	logic                       hold_req = 1'b0;
	logic                       hold_seen = 1'b0;
	int                         hold_left = 0;

	segregated_pool_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.req_size    (req_size),
		.block_addr  (block_addr),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result_addr (result_addr),
		.status      (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// smallest class that holds the request plus its header
	function automatic int block_class(int unsigned bytes);
		int c;
		c = 0;
		while (c < spa_pkg::NUM_CLASSES - 1
				&& (1 << (c + spa_pkg::SLOT_SHIFT)) < bytes + spa_pkg::HDR_BYTES)
			c++;
		return c;
	endfunction

	function automatic grant_t allocate_or_release(logic op, logic [spa_pkg::SIZE_W-1:0] size,
			logic [spa_pkg::ADDR_W-1:0] ptr);
		grant_t      g;
		int unsigned c, slot, step, count, base, off, s;
		g.addr = '0;
		g.status = spa_pkg::STAT_OK;
		if (op == spa_pkg::KIND_FREE) begin
			if (ptr < spa_pkg::HDR_BYTES)
				return g;
			off = ptr - spa_pkg::HDR_BYTES;
			if ((off & ((1 << spa_pkg::SLOT_SHIFT) - 1)) != 0)
				return g;
			slot = off >> spa_pkg::SLOT_SHIFT;
			if (slot >= carved * SLOTS_PER_CHUNK)
				return g;
			c = slot_hdr[slot].cls;
			slot_hdr[slot].has_next = head_valid[c];
			slot_hdr[slot].next = head_slot[c];
			head_valid[c] = 1'b1;
			head_slot[c] = spa_pkg::SLOT_W'(slot);
		end else if (size == 0) begin
			g.status = spa_pkg::STAT_ZERO;
		end else if (size > spa_pkg::MAX_SMALL) begin
			g.status = spa_pkg::STAT_TOO_BIG;
		end else begin
			c = block_class(size);
			if (head_valid[c]) begin
				slot = head_slot[c];
				head_valid[c] = slot_hdr[slot].has_next;
				head_slot[c] = slot_hdr[slot].next;
				g.addr = spa_pkg::ADDR_W'((slot << spa_pkg::SLOT_SHIFT) + spa_pkg::HDR_BYTES);
			end else if (carved >= spa_pkg::POOL_CHUNKS) begin
				g.status = spa_pkg::STAT_EXHAUSTED;
			end else begin
				// carve the next chunk into a linked run of blocks
				step = 1 << c;
				count = SLOTS_PER_CHUNK >> c;
				base = carved * SLOTS_PER_CHUNK;
				for (int unsigned i = 0; i < count; i++) begin
					s = base + i * step;
					slot_hdr[s].cls = spa_pkg::CLS_W'(c);
					slot_hdr[s].has_next = (i + 1 < count);
					slot_hdr[s].next = (i + 1 < count) ? spa_pkg::SLOT_W'(s + step) : '0;
				end
				carved++;
				head_valid[c] = (count > 1);
				head_slot[c] = (count > 1) ? spa_pkg::SLOT_W'(base + step) : '0;
				g.addr = spa_pkg::ADDR_W'((base << spa_pkg::SLOT_SHIFT) + spa_pkg::HDR_BYTES);
			end
		end
		return g;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		err_count++;
	endtask

	task automatic offer(input logic op, input logic [spa_pkg::SIZE_W-1:0] size,
			input logic [spa_pkg::ADDR_W-1:0] ptr, input bit known,
			input logic [spa_pkg::ADDR_W-1:0] want_addr, input logic [1:0] want_status);
		grant_t g;
		bit     removed;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= op;
		req_size <= size;
		block_addr <= ptr;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		g = allocate_or_release(op, size, ptr);
		if (known) begin
			g.addr = want_addr;
			g.status = want_status;
		end
		if (op == spa_pkg::KIND_ALLOC && g.status == spa_pkg::STAT_OK)
			live_ptrs.push_back(g.addr);
		if (op == spa_pkg::KIND_FREE) begin
			removed = 1'b0;
			foreach (live_ptrs[i]) begin
				if (!removed && live_ptrs[i] == ptr) begin
					live_ptrs.delete(i);
					removed = 1'b1;
				end
			end
		end
		if (g.status == spa_pkg::STAT_EXHAUSTED)
			exhausted_seen = 1'b1;
		pending_grants.push_back(g);
	endtask

	task automatic await_all_grants();
		req_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item(input mix_t mix);
		int unsigned                pick, c, lo, hi, slot;
		logic [spa_pkg::ADDR_W-1:0] ptr;
		logic [spa_pkg::SIZE_W-1:0] size;
		pick = $urandom_range(99);
		ptr = spa_pkg::ADDR_W'($urandom);
		size = spa_pkg::SIZE_W'($urandom);
		if (pick < 10) begin
			// malformed or degenerate requests
			case ($urandom_range(5))
				0: offer(spa_pkg::KIND_ALLOC, '0, ptr, 1'b0, '0, spa_pkg::STAT_OK);
				1: offer(spa_pkg::KIND_ALLOC, spa_pkg::SIZE_W'($urandom_range(
						spa_pkg::MAX_SMALL + 1, (1 << spa_pkg::SIZE_W) - 1)),
						ptr, 1'b0, '0, spa_pkg::STAT_OK);
				2: offer(spa_pkg::KIND_FREE, size, '0, 1'b0, '0, spa_pkg::STAT_OK);
				3: offer(spa_pkg::KIND_FREE, size,
						spa_pkg::ADDR_W'($urandom_range(1, spa_pkg::HDR_BYTES - 1)),
						1'b0, '0, spa_pkg::STAT_OK);
				4: begin
					ptr = spa_pkg::ADDR_W'($urandom_range(spa_pkg::HDR_BYTES,
						(1 << spa_pkg::ADDR_W) - 1));
					if (((ptr - spa_pkg::HDR_BYTES) & ((1 << spa_pkg::SLOT_SHIFT) - 1)) == 0)
						ptr ^= 1;
					offer(spa_pkg::KIND_FREE, size, ptr, 1'b0, '0, spa_pkg::STAT_OK);
				end
				default: begin
					// aligned pointer past the carved region, or a misaligned one once the pool is full
					if (carved < spa_pkg::POOL_CHUNKS) begin
						slot = $urandom_range(carved * SLOTS_PER_CHUNK, spa_pkg::NUM_SLOTS - 1);
						ptr = spa_pkg::ADDR_W'((slot << spa_pkg::SLOT_SHIFT)
							+ spa_pkg::HDR_BYTES);
					end else begin
						ptr = spa_pkg::ADDR_W'(spa_pkg::HDR_BYTES + 1);
					end
					offer(spa_pkg::KIND_FREE, size, ptr, 1'b0, '0, spa_pkg::STAT_OK);
				end
			endcase
		end else if (mix == MIX_GENERAL && pick < 45 && live_ptrs.size() != 0) begin
			ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
			offer(spa_pkg::KIND_FREE, size, ptr, 1'b0, '0, spa_pkg::STAT_OK);
		end else begin
			c = (mix == MIX_FILL) ? spa_pkg::NUM_CLASSES - 1
				: $urandom_range(spa_pkg::NUM_CLASSES - 1);
			lo = (c == 0) ? 1
				: (1 << (c + spa_pkg::SLOT_SHIFT - 1)) - spa_pkg::HDR_BYTES + 1;
			hi = (1 << (c + spa_pkg::SLOT_SHIFT)) - spa_pkg::HDR_BYTES;
			case ($urandom_range(3))
				0: size = spa_pkg::SIZE_W'(lo);
				1: size = spa_pkg::SIZE_W'(hi);
				default: size = spa_pkg::SIZE_W'($urandom_range(lo, hi));
			endcase
			offer(spa_pkg::KIND_ALLOC, size, ptr, 1'b0, '0, spa_pkg::STAT_OK);
		end
	endtask

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		grant_t g;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_grants.size() == 0) begin
				flag_mismatch($sformatf("unexpected result addr %0d status %0d",
					result_addr, status));
			end else begin
				g = pending_grants.pop_front();
				if (result_addr !== g.addr)
					flag_mismatch($sformatf("result_addr %0d, expected %0d",
						result_addr, g.addr));
				if (status !== g.status)
					flag_mismatch($sformatf("status %0d, expected %0d", status, g.status));
			end
		end
	end

	initial begin
		int guard;
		dir_rows = '{
			'{spa_pkg::KIND_ALLOC, 16'd1,    18'h3FFFF,  1'b1, 18'd8,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd24,   18'd0,      1'b1, 18'd40,   spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd25,   18'd0,      1'b1, 18'd4104, spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd4088, 18'd0,      1'b1, 18'd8200, spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd4089, 18'd0,      1'b1, 18'd0,    spa_pkg::STAT_TOO_BIG},
			'{spa_pkg::KIND_ALLOC, 16'hFFFF, 18'h3FFFF,  1'b1, 18'd0,    spa_pkg::STAT_TOO_BIG},
			'{spa_pkg::KIND_ALLOC, 16'd0,    18'd0,      1'b1, 18'd0,    spa_pkg::STAT_ZERO},
			'{spa_pkg::KIND_FREE,  16'hFFFF, 18'd0,      1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'd4,      1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'h3FFFF,  1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'd262120, 1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'd8,      1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd1,    18'd0,      1'b1, 18'd8,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd2040, 18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd2041, 18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'd40,     1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'd8200,   1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd100,  18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd4000, 18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd24,   18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK},
			// double free of a 2048-byte block: that list loops on itself from here on
			'{spa_pkg::KIND_FREE,  16'd0,    18'd12296,  1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_FREE,  16'd0,    18'd12296,  1'b1, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd2000, 18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK},
			'{spa_pkg::KIND_ALLOC, 16'd2000, 18'd0,      1'b0, 18'd0,    spa_pkg::STAT_OK}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].op, dir_rows[i].size, dir_rows[i].ptr, dir_rows[i].known,
				dir_rows[i].want_addr, dir_rows[i].want_status);
		await_all_grants();

		repeat (100) random_item(MIX_GENERAL);
		send_idle_pct = 67;
		repeat (80) random_item(MIX_GENERAL);
		await_all_grants();

		// fill the pool with 4096-byte blocks while the receiver holds off
		send_idle_pct = 0;
		stall_pct = 67;
		hold_req <= ~hold_req;
		guard = 0;
		while (!exhausted_seen && guard < 300) begin
			random_item(MIX_FILL);
			guard++;
		end
		repeat (20) random_item(MIX_GENERAL);
		await_all_grants();

		send_idle_pct = 28;
		stall_pct = 28;
		repeat (100) random_item(MIX_GENERAL);
		await_all_grants();

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (40) random_item(MIX_GENERAL);

		await_all_grants();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### segregated_pool_allocator.f
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_datapath.sv
rtl/spa_ctrl.sv
rtl/segregated_pool_allocator.sv
sim/tb_top.sv
